// ===== design/rifm_pkg.sv =====
// Shared types and constants for the first-match IP route forwarder.
// Used by rifm_cell, rifm_chain and ip_route_first_match_forwarder.
package rifm_pkg;

  localparam int MAX_ROUTES = 16;
  localparam int CNT_W      = $clog2(MAX_ROUTES + 1);
  localparam int ADDR_W     = 32;
  localparam int TTL_W      = 8;
  localparam int SIZE_W     = 16;
  localparam int HLEN_W     = 8;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_UP    = 2'd2,
    KIND_DOWN  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_DELIVER  = 3'd0,
    ACT_SEND     = 3'd1,
    ACT_TTL_DROP = 3'd2,
    ACT_UNREACH  = 3'd3,
    ACT_UPDATED  = 3'd4,
    ACT_FULL     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    REG_DEFAULT_TTL   = 2'd0,
    REG_HEADER_LENGTH = 2'd1,
    REG_BROADCAST     = 2'd2
  } reg_index_t;

  // Token walking the route chain. pos counts cells left before the write
  // slot (route add) or before the end of the used entries (lookup).
  typedef struct packed {
    logic              valid;
    logic              is_write;
    logic              done;
    logic [CNT_W-1:0]  pos;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
  } token_t;

endpackage

// ===== design/rifm_cell.sv =====
// One route table entry plus one token stage of the lookup chain.
// Depends on rifm_pkg.
module rifm_cell (
  input  logic             clk,
  input  logic             rst,
  input  rifm_pkg::token_t tok_in,
  output rifm_pkg::token_t tok_out
);

  logic [rifm_pkg::ADDR_W-1:0] net;
  logic [rifm_pkg::ADDR_W-1:0] netmask;
  logic [rifm_pkg::ADDR_W-1:0] hop;
  rifm_pkg::token_t            tok_next;
  logic                        write_hit;
  logic                        lookup_hit;

  assign write_hit = tok_in.valid && tok_in.is_write && !tok_in.done &&
                     (tok_in.pos == '0);
  assign lookup_hit = tok_in.valid && !tok_in.is_write && !tok_in.done &&
                      (tok_in.pos != '0) &&
                      ((tok_in.addr & netmask) == (net & netmask));

  always_comb begin
    tok_next = tok_in;
    if (tok_in.pos != '0) begin
      tok_next.pos = tok_in.pos - rifm_pkg::CNT_W'(1);
    end
    if (write_hit) begin
      tok_next.done = 1'b1;
    end
    if (lookup_hit) begin
      tok_next.done = 1'b1;
      tok_next.hop  = hop;
    end
  end

  always_ff @(posedge clk) begin
    if (write_hit) begin
      net     <= tok_in.addr;
      netmask <= tok_in.mask;
      hop     <= tok_in.hop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.is_write <= tok_next.is_write;
    tok_out.done     <= tok_next.done;
    tok_out.pos      <= tok_next.pos;
    tok_out.addr     <= tok_next.addr;
    tok_out.mask     <= tok_next.mask;
    tok_out.hop      <= tok_next.hop;
  end

endmodule

// ===== design/rifm_chain.sv =====
// Row of MAX_ROUTES route cells; a token advances one cell per cycle.
// Depends on rifm_pkg and rifm_cell.
module rifm_chain (
  input  logic             clk,
  input  logic             rst,
  input  rifm_pkg::token_t head,
  output rifm_pkg::token_t tail
);

  rifm_pkg::token_t link [0:rifm_pkg::MAX_ROUTES];

  assign link[0] = head;

  for (genvar i = 0; i < rifm_pkg::MAX_ROUTES; i++) begin : g_cell
    rifm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  assign tail = link[rifm_pkg::MAX_ROUTES];

endmodule

// ===== design/ip_route_first_match_forwarder.sv =====
// Static IP route table with first-match forwarding; top level.
// Depends on rifm_pkg and rifm_chain.
//
// One item is handled at a time. Clears, adds to a full table, deliveries
// and TTL drops go from the accept straight to the pending state, which
// loads the result register once the output is free. Route adds and route
// lookups first walk a chain of MAX_ROUTES cells, one cell per cycle. The
// next item is taken as soon as the result is in the output register,
// even if it is stalled.
// Configuration writes are always ready.
module ip_route_first_match_forwarder (
  input  logic                        clk,
  input  logic                        rst,
  // item input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  kind,
  input  logic [rifm_pkg::ADDR_W-1:0] route_destination,
  input  logic [rifm_pkg::ADDR_W-1:0] route_mask,
  input  logic [rifm_pkg::ADDR_W-1:0] route_gateway,
  input  logic [rifm_pkg::ADDR_W-1:0] packet_destination,
  input  logic [rifm_pkg::ADDR_W-1:0] arrived_hop,
  input  logic [rifm_pkg::TTL_W-1:0]  packet_ttl,
  input  logic [rifm_pkg::SIZE_W-1:0] packet_size,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  action,
  output logic [rifm_pkg::ADDR_W-1:0] chosen_hop,
  output logic [rifm_pkg::TTL_W-1:0]  ttl_out,
  output logic [rifm_pkg::SIZE_W-1:0] size_out,
  output logic [rifm_pkg::CNT_W-1:0]  route_count,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PEND
  } state_t;

  state_t                      state;
  logic [rifm_pkg::CNT_W-1:0]  entries_used;
  logic [rifm_pkg::TTL_W-1:0]  default_ttl;
  logic [rifm_pkg::HLEN_W-1:0] header_length;
  logic [rifm_pkg::ADDR_W-1:0] broadcast_address;

  rifm_pkg::action_t           pend_action;
  logic [rifm_pkg::ADDR_W-1:0] pend_hop;
  logic [rifm_pkg::TTL_W-1:0]  pend_ttl;
  logic [rifm_pkg::SIZE_W-1:0] pend_size;
  logic [rifm_pkg::CNT_W-1:0]  pend_count;

  rifm_pkg::action_t           item_action;
  logic [rifm_pkg::TTL_W-1:0]  item_ttl;
  logic [rifm_pkg::SIZE_W-1:0] item_size;
  logic [rifm_pkg::CNT_W-1:0]  item_count;
  logic                        item_walk;
  logic                        item_write;

  logic                        in_accept;
  logic                        out_take;
  logic                        out_free;
  logic                        out_load;
  logic                        table_full;
  logic                        deliver;
  logic [rifm_pkg::SIZE_W:0]   size_dn;
  logic [rifm_pkg::SIZE_W:0]   size_up;
  rifm_pkg::token_t            head;
  rifm_pkg::token_t            tail;

  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_take   = out_valid && !out_stall;
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = (state == ST_PEND) && out_free;
  assign cfg_ready  = 1'b1;
  assign table_full = (entries_used == rifm_pkg::CNT_W'(rifm_pkg::MAX_ROUTES));
  assign deliver    = (packet_destination == arrived_hop) ||
                      (packet_destination == broadcast_address);

  // borrow bit set when the header is longer than the packet
  assign size_dn = {1'b0, packet_size} -
                   {{(rifm_pkg::SIZE_W + 1 - rifm_pkg::HLEN_W){1'b0}}, header_length};
  assign size_up = {1'b0, packet_size} +
                   {{(rifm_pkg::SIZE_W + 1 - rifm_pkg::HLEN_W){1'b0}}, header_length};

  always_comb begin
    item_action = rifm_pkg::ACT_UPDATED;
    item_ttl    = '0;
    item_size   = '0;
    item_count  = entries_used;
    item_walk   = 1'b0;
    item_write  = 1'b0;
    case (rifm_pkg::kind_t'(kind))
      rifm_pkg::KIND_CLEAR: begin
        item_count = '0;
      end
      rifm_pkg::KIND_ADD: begin
        if (table_full) begin
          item_action = rifm_pkg::ACT_FULL;
        end else begin
          item_count = entries_used + rifm_pkg::CNT_W'(1);
          item_walk  = 1'b1;
          item_write = 1'b1;
        end
      end
      rifm_pkg::KIND_UP: begin
        if (deliver) begin
          item_action = rifm_pkg::ACT_DELIVER;
          item_ttl    = packet_ttl;
          item_size   = size_dn[rifm_pkg::SIZE_W] ? '0 : size_dn[rifm_pkg::SIZE_W-1:0];
        end else begin
          item_size = packet_size;
          if (packet_ttl <= rifm_pkg::TTL_W'(1)) begin
            item_action = rifm_pkg::ACT_TTL_DROP;
          end else begin
            item_ttl  = packet_ttl - rifm_pkg::TTL_W'(1);
            item_walk = 1'b1;
          end
        end
      end
      rifm_pkg::KIND_DOWN: begin
        item_ttl  = default_ttl;
        item_size = size_up[rifm_pkg::SIZE_W] ? '1 : size_up[rifm_pkg::SIZE_W-1:0];
        item_walk = 1'b1;
      end
      default: begin
        item_action = rifm_pkg::ACT_UPDATED;
      end
    endcase
  end

  always_comb begin
    head.valid    = in_accept && item_walk;
    head.is_write = item_write;
    head.done     = 1'b0;
    head.pos      = entries_used;
    head.addr     = item_write ? route_destination : packet_destination;
    head.mask     = route_mask;
    head.hop      = item_write ? route_gateway : '0;
  end

  rifm_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .tail (tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      entries_used      <= '0;
      default_ttl       <= rifm_pkg::TTL_W'(32);
      header_length     <= rifm_pkg::HLEN_W'(20);
      broadcast_address <= '1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (rifm_pkg::reg_index_t'(cfg_index))
          rifm_pkg::REG_DEFAULT_TTL:   default_ttl       <= cfg_data[rifm_pkg::TTL_W-1:0];
          rifm_pkg::REG_HEADER_LENGTH: header_length     <= cfg_data[rifm_pkg::HLEN_W-1:0];
          rifm_pkg::REG_BROADCAST:     broadcast_address <= cfg_data[rifm_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      if (out_take && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            entries_used <= item_count;
            pend_action  <= item_action;
            pend_hop     <= '0;
            pend_ttl     <= item_ttl;
            pend_size    <= item_size;
            pend_count   <= item_count;
            state        <= item_walk ? ST_WALK : ST_PEND;
          end
        end
        ST_WALK: begin
          if (tail.valid) begin
            if (!tail.is_write) begin
              pend_hop    <= tail.hop;
              pend_action <= (tail.hop != '0) ? rifm_pkg::ACT_SEND : rifm_pkg::ACT_UNREACH;
            end
            state <= ST_PEND;
          end
        end
        ST_PEND: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            action      <= pend_action;
            chosen_hop  <= pend_hop;
            ttl_out     <= pend_ttl;
            size_out    <= pend_size;
            route_count <= pend_count;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a token only leaves the chain while its item is waiting on it
  assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == ST_WALK))
    else $error("route chain token outside of a walk");

  assert property (@(posedge clk) disable iff (rst)
    entries_used <= rifm_pkg::CNT_W'(rifm_pkg::MAX_ROUTES))
    else $error("route count beyond table size");

  // a table clear, with no lookup and no write, goes straight to the result stage
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (kind == rifm_pkg::KIND_CLEAR)) |=> (state == ST_PEND))
    else $error("table clear did not complete at once");

endmodule
